[design/frenet_to_cartesian_unit_defines.svh]
// Assertion macros for the frenet-to-cartesian top-level design file.
`ifndef FRENET_TO_CARTESIAN_UNIT_DEFINES_SVH
`define FRENET_TO_CARTESIAN_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define F2C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define F2C_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/f2c_pkg.sv]
// Shared constants and types for the frenet-to-cartesian unit.
`timescale 1ns / 1ps
package f2c_pkg;
    localparam int MAX_WAYPOINTS = 256;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int FRAC_BITS     = 16;
    localparam int COORD_W       = 32;
    localparam int ARC_W         = 31;
    localparam int MAG_W         = COORD_W + 1;
    localparam int AXIS_W        = 31;
    localparam int SQ_W          = 2 * AXIS_W + 1;
    localparam int ROOT_W        = 32;
    localparam int SQRT_STEPS    = (SQ_W + 1) / 2;
    localparam int NUM_W         = AXIS_W + FRAC_BITS + 1;
    localparam int QUO_W         = FRAC_BITS + 1;
    localparam int UNIT_W        = QUO_W + 1;
    localparam int PROD_W        = COORD_W + UNIT_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int RND_W         = ACC_W - FRAC_BITS + 1;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_ZERO_SEG = 2'd1;
    localparam t_status STATUS_EMPTY    = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;
endpackage

[design/frenet_to_cartesian_unit.sv]
// Top level: waypoint tables, search sequencer and fixed-point conversion datapath.
`timescale 1ns / 1ps
`include "frenet_to_cartesian_unit_defines.svh"
// Frenet-to-cartesian converter over a waypoint table held in three RAMs.
// Config: write i_cfg_data into the waypoint count while i_cfg_we is high; do so
//   only when the block is idle.
// Input channel (i_in_valid / o_in_stall): a load beat writes entry_x, entry_y and
//   entry_arc at entry_index and gives no result. A convert beat takes query_s and
//   query_d and gives one result beat (x, y, status).
// Output channel (o_out_valid / i_out_stall): an output register holds the result;
//   new beats are taken while it waits, and a stall holds it unchanged.
// One item at a time; a load leaves the sequencer idle. A convert with an empty
//   table goes straight to the done state; otherwise it runs the arc search up to the
//   index i where it stops (one table entry per cycle through the arc RAM read port),
//   then up to 30 normalize shifts, 32 square root steps and 17 divide steps.
// The finished result waits in its state until the output register is free.
// Reset (synchronous, i_rst_n low) clears the count, the sequencer and the output
//   valid; table contents are undefined until loaded.
module frenet_to_cartesian_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [f2c_pkg::CNT_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [f2c_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [f2c_pkg::COORD_W-1:0] i_entry_x,
    input  logic signed [f2c_pkg::COORD_W-1:0] i_entry_y,
    input  logic [f2c_pkg::ARC_W-1:0]          i_entry_arc,
    input  logic [f2c_pkg::ARC_W-1:0]          i_query_s,
    input  logic signed [f2c_pkg::COORD_W-1:0] i_query_d,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [f2c_pkg::COORD_W-1:0] o_out_x,
    output logic signed [f2c_pkg::COORD_W-1:0] o_out_y,
    output logic [1:0]                         o_status
);
    import f2c_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'd1 << 0,
        S_SRCH0     = 17'd1 << 1,
        S_SEARCH    = 17'd1 << 2,
        S_FETCH_P   = 17'd1 << 3,
        S_FETCH_N   = 17'd1 << 4,
        S_FETCH_D   = 17'd1 << 5,
        S_NORM      = 17'd1 << 6,
        S_SQ        = 17'd1 << 7,
        S_SQRT_GO   = 17'd1 << 8,
        S_SQRT_WAIT = 17'd1 << 9,
        S_DIV_GO    = 17'd1 << 10,
        S_DIV_WAIT  = 17'd1 << 11,
        S_MUL       = 17'd1 << 12,
        S_SUM       = 17'd1 << 13,
        S_RND       = 17'd1 << 14,
        S_FIN       = 17'd1 << 15,
        S_DONE      = 17'd1 << 16
    } t_state;

    localparam logic [ACC_W:0] HALF_LSB = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_wp_count;
    logic [CNT_W-1:0] w_n;
    logic w_in_acc, w_load, w_conv, w_out_free;

    logic [IDX_W-1:0]   w_raddr;
    logic [COORD_W-1:0] w_x_rd, w_y_rd;
    logic [ARC_W-1:0]   w_arc_rd;

    logic [ARC_W-1:0]          r_qs;
    logic signed [COORD_W-1:0] r_d;
    logic [CNT_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_prev, r_next;
    logic                      w_more;
    logic [CNT_W-1:0]          w_prev_full, w_next_full;

    logic signed [COORD_W-1:0] r_px, r_py;
    logic [ARC_W-1:0]          r_parc;
    logic signed [COORD_W-1:0] r_seg;
    logic signed [MAG_W-1:0]   w_dx, w_dy;
    logic [MAG_W-1:0]          w_dx_mag, w_dy_mag, w_m;
    logic [MAG_W-1:0]          r_ax, r_ay;
    logic                      r_sx, r_sy;
    logic [SQ_W-1:0]           r_sq;

    logic [ROOT_W-1:0] w_root, r_len;
    logic              w_sqrt_done;
    logic [NUM_W-1:0]  r_num_x, r_num_y;
    logic [QUO_W-1:0]  w_qx, w_qy;
    logic              w_divx_done, w_divy_done;

    logic signed [UNIT_W-1:0] r_ux, r_uy;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [ACC_W-1:0]  r_tx, r_ty;
    logic signed [RND_W-1:0]  r_qx, r_qy;
    logic signed [RND_W:0]    w_fx, w_fy;

    logic [COORD_W-1:0] r_res_x, r_res_y;
    t_status            r_res_st;

    function automatic logic [RND_W-1:0] round_frac(input logic [ACC_W-1:0] t);
        logic [ACC_W-1:0] mag;
        logic [ACC_W:0]   sum;
        logic [RND_W-1:0] q;
        mag = t[ACC_W-1] ? (~t + 1'b1) : t;
        sum = {1'b0, mag} + HALF_LSB;
        q   = sum[ACC_W:FRAC_BITS];
        return t[ACC_W-1] ? (~q + 1'b1) : q;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic [RND_W:0] v);
        logic [RND_W-COORD_W+1:0] top;
        top = v[RND_W:COORD_W-1];
        if (top == '0 || top == '1) begin
            return v[COORD_W-1:0];
        end else if (v[RND_W]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    assign w_n        = (r_wp_count > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : r_wp_count;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load     = w_in_acc && (i_operation == OP_LOAD);
    assign w_conv     = w_in_acc && (i_operation == OP_CONVERT);
    assign w_out_free = !o_out_valid || !i_out_stall;

    f2c_ram #(.WIDTH(COORD_W), .DEPTH(MAX_WAYPOINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(i_entry_index), .i_wdata(i_entry_x),
        .i_raddr(w_raddr), .o_rdata(w_x_rd)
    );
    f2c_ram #(.WIDTH(COORD_W), .DEPTH(MAX_WAYPOINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(i_entry_index), .i_wdata(i_entry_y),
        .i_raddr(w_raddr), .o_rdata(w_y_rd)
    );
    f2c_ram #(.WIDTH(ARC_W), .DEPTH(MAX_WAYPOINTS)) u_arc_ram (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(i_entry_index), .i_wdata(i_entry_arc),
        .i_raddr(w_raddr), .o_rdata(w_arc_rd)
    );

    // read ahead one entry during the search so the compare sees one entry a cycle
    always_comb begin
        priority if (r_state == S_SRCH0) begin
            w_raddr = '0;
        end else if (r_state == S_SEARCH) begin
            w_raddr = r_idx[IDX_W-1:0] + 1'b1;
        end else if (r_state == S_FETCH_N) begin
            w_raddr = r_next;
        end else begin
            w_raddr = r_prev;
        end
    end

    assign w_more      = (r_idx < w_n) && (r_qs > w_arc_rd);
    assign w_prev_full = (r_idx == '0) ? '0 : r_idx - 1'b1;
    assign w_next_full = ((w_prev_full + 1'b1) == w_n) ? '0 : w_prev_full + 1'b1;

    assign w_dx     = $signed({w_x_rd[COORD_W-1], w_x_rd}) - $signed({r_px[COORD_W-1], r_px});
    assign w_dy     = $signed({w_y_rd[COORD_W-1], w_y_rd}) - $signed({r_py[COORD_W-1], r_py});
    assign w_dx_mag = w_dx[MAG_W-1] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_mag = w_dy[MAG_W-1] ? (~w_dy + 1'b1) : w_dy;
    assign w_m      = r_ax | r_ay;

    assign w_fx = $signed({{(RND_W + 1 - COORD_W){r_px[COORD_W-1]}}, r_px})
                + $signed({r_qx[RND_W-1], r_qx});
    assign w_fy = $signed({{(RND_W + 1 - COORD_W){r_py[COORD_W-1]}}, r_py})
                + $signed({r_qy[RND_W-1], r_qy});

    f2c_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_SQRT_GO),
        .i_radicand(r_sq), .o_root(w_root), .o_done(w_sqrt_done)
    );
    f2c_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_DIV_GO),
        .i_num(r_num_x), .i_den(r_len), .o_quo(w_qx), .o_done(w_divx_done)
    );
    f2c_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_DIV_GO),
        .i_num(r_num_y), .i_den(r_len), .o_quo(w_qy), .o_done(w_divy_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_conv) begin
                    n_state = (w_n == '0) ? S_DONE : S_SRCH0;
                end
            end
            S_SRCH0:   n_state = S_SEARCH;
            S_SEARCH: begin
                if (!w_more) begin
                    n_state = S_FETCH_P;
                end
            end
            S_FETCH_P: n_state = S_FETCH_N;
            S_FETCH_N: n_state = S_FETCH_D;
            S_FETCH_D: n_state = (w_dx == '0 && w_dy == '0) ? S_DONE : S_NORM;
            S_NORM: begin
                if (w_m[MAG_W-1:AXIS_W] == '0 && w_m[AXIS_W-1]) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:        n_state = S_SQRT_GO;
            S_SQRT_GO:   n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (w_sqrt_done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_divx_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_RND;
            S_RND:  n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp_count <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wp_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qs     <= i_query_s;
                r_d      <= i_query_d;
                r_idx    <= '0;
                r_res_x  <= '0;
                r_res_y  <= '0;
                r_res_st <= STATUS_EMPTY;
            end
            S_SEARCH: begin
                if (w_more) begin
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_prev <= w_prev_full[IDX_W-1:0];
                    r_next <= w_next_full[IDX_W-1:0];
                end
            end
            S_FETCH_N: begin
                r_px   <= w_x_rd;
                r_py   <= w_y_rd;
                r_parc <= w_arc_rd;
            end
            S_FETCH_D: begin
                r_seg    <= $signed({1'b0, r_qs}) - $signed({1'b0, r_parc});
                r_ax     <= w_dx_mag;
                r_ay     <= w_dy_mag;
                r_sx     <= w_dx[MAG_W-1];
                r_sy     <= w_dy[MAG_W-1];
                r_res_x  <= r_px;
                r_res_y  <= r_py;
                r_res_st <= STATUS_ZERO_SEG;
            end
            S_NORM: begin
                if (w_m[MAG_W-1:AXIS_W] != '0) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else if (!w_m[AXIS_W-1]) begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            S_SQ: begin
                r_sq <= SQ_W'(r_ax[AXIS_W-1:0] * r_ax[AXIS_W-1:0])
                      + SQ_W'(r_ay[AXIS_W-1:0] * r_ay[AXIS_W-1:0]);
            end
            S_SQRT_WAIT: begin
                r_len   <= w_root;
                r_num_x <= NUM_W'({r_ax[AXIS_W-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(w_root >> 1);
                r_num_y <= NUM_W'({r_ay[AXIS_W-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(w_root >> 1);
            end
            S_DIV_WAIT: begin
                r_ux <= r_sx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
                r_uy <= r_sy ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
            end
            S_MUL: begin
                r_p1 <= r_seg * r_ux;
                r_p2 <= r_d * r_uy;
                r_p3 <= r_seg * r_uy;
                r_p4 <= r_d * r_ux;
            end
            S_SUM: begin
                r_tx <= $signed({r_p1[PROD_W-1], r_p1}) + $signed({r_p2[PROD_W-1], r_p2});
                r_ty <= $signed({r_p3[PROD_W-1], r_p3}) - $signed({r_p4[PROD_W-1], r_p4});
            end
            S_RND: begin
                r_qx <= round_frac(r_tx);
                r_qy <= round_frac(r_ty);
            end
            S_FIN: begin
                r_res_x  <= sat_coord(w_fx);
                r_res_y  <= sat_coord(w_fy);
                r_res_st <= STATUS_OK;
            end
            default: begin
            end
        endcase
    end

    // output register: load from the done state, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            o_out_x  <= r_res_x;
            o_out_y  <= r_res_y;
            o_status <= r_res_st;
        end
    end

    `F2C_ASSERT_IMP(a_len_norm, (r_state == S_SQRT_WAIT) && w_sqrt_done,
        w_root[ROOT_W-1:ROOT_W-2] != 2'b00, "segment length not normalized")
    `F2C_ASSERT_IMP(a_div_sync, r_state == S_DIV_WAIT,
        w_divx_done == w_divy_done, "unit vector dividers out of step")
    `F2C_ASSERT_IMP(a_unit_max, (r_state == S_DIV_WAIT) && w_divx_done,
        (w_qx <= (QUO_W'(1) << FRAC_BITS)) && (w_qy <= (QUO_W'(1) << FRAC_BITS)),
        "unit vector component above one")
    `F2C_ASSERT_IMP(a_prev_range, r_state == S_FETCH_P,
        CNT_W'(r_prev) < w_n, "previous waypoint beyond table")
    `F2C_ASSERT_NXT(a_result_out, (r_state == S_DONE) && w_out_free,
        o_out_valid && (r_state == S_IDLE), "result beat not presented")
endmodule

[design/f2c_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module f2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/f2c_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module f2c_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [f2c_pkg::SQ_W-1:0]    i_radicand,
    output logic [f2c_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_done
);
    import f2c_pkg::*;

    localparam int STEP_W = $clog2(SQRT_STEPS + 1);
    localparam logic [SQ_W:0] BIT_INIT = (SQ_W + 1)'(1) << (2 * (SQRT_STEPS - 1));

    logic [SQ_W:0]   r_rem;
    logic [SQ_W:0]   r_root;
    logic [SQ_W:0]   r_bit;
    logic [STEP_W-1:0] r_steps;
    logic            r_done;
    logic [SQ_W:0]   w_trial;
    logic            w_fit;

    assign w_trial = r_root + r_bit;
    assign w_fit   = (r_rem >= w_trial);
    assign o_root  = r_root[ROOT_W-1:0];
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_steps == STEP_W'(1));
            if (i_start) begin
                r_steps <= STEP_W'(SQRT_STEPS);
            end else if (r_steps != '0) begin
                r_steps <= r_steps - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_radicand};
            r_root <= '0;
            r_bit  <= BIT_INIT;
        end else if (r_steps != '0) begin
            if (w_fit) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule

[design/f2c_div.sv]
// Restoring divider for the unit vector, one quotient bit per cycle.
`timescale 1ns / 1ps
module f2c_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [f2c_pkg::NUM_W-1:0]  i_num,
    input  logic [f2c_pkg::ROOT_W-1:0] i_den,
    output logic [f2c_pkg::QUO_W-1:0]  o_quo,
    output logic                       o_done
);
    import f2c_pkg::*;

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_den;
    logic [QUO_W-1:0]  r_lo;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_steps;
    logic              r_done;
    logic [ROOT_W:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_lo[QUO_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign o_quo   = r_quo;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_steps == STEP_W'(1));
            if (i_start) begin
                r_steps <= STEP_W'(QUO_W);
            end else if (r_steps != '0) begin
                r_steps <= r_steps - 1'b1;
            end
        end
    end

    // the upper numerator bits are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= ROOT_W'(i_num[NUM_W-1:QUO_W]);
            r_lo  <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_steps != '0) begin
            r_rem <= w_fit ? ROOT_W'(w_trial - {1'b0, r_den}) : w_trial[ROOT_W-1:0];
            r_lo  <= r_lo << 1;
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end
endmodule
